[rtl/core/lsdmc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Door motor controller package
// Field widths, codes and register indexes shared by the controller and its
// channel interfaces.
// ----------------------------------------------------------------------------
package lsdmc_pkg;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned DIR_W      = 2;
  localparam int unsigned REASON_W   = 3;
  localparam int unsigned POS_W      = 2;
  localparam int unsigned STABLE_W   = 16;
  localparam int unsigned TMO_W      = 20;
  localparam int unsigned CNT_W      = 17;
  localparam int unsigned ELAP_W     = 20;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [STABLE_W-1:0] STABLE_RESET = 16'd50;
  localparam logic [TMO_W-1:0]    TMO_RESET    = 20'd10000;
  localparam logic [CNT_W-1:0]    CNT_MAX      = {CNT_W{1'b1}};
  localparam logic [ELAP_W-1:0]   ELAP_MAX     = {ELAP_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_OPEN  = 2'd1,
    OP_CLOSE = 2'd2
  } op_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_NONE  = 2'd0,
    DIR_OPEN  = 2'd1,
    DIR_CLOSE = 2'd2
  } dir_t;

  typedef enum logic [REASON_W-1:0] {
    RSN_NONE     = 3'd0,
    RSN_OPENED   = 3'd1,
    RSN_CLOSED   = 3'd2,
    RSN_CONFLICT = 3'd3,
    RSN_TIMEOUT  = 3'd4
  } reason_t;

  typedef enum logic [POS_W-1:0] {
    POS_BETWEEN  = 2'd0,
    POS_OPEN     = 2'd1,
    POS_CLOSED   = 2'd2,
    POS_CONFLICT = 2'd3
  } pos_t;

  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_STABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_TIMEOUT = 2'd1;

endpackage

[rtl/core/lsdmc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Door motor controller channels
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface lsdmc_in_if;
  logic                       valid;
  logic                       ready;
  logic [lsdmc_pkg::OP_W-1:0] op;
  logic                       open_sensor_level;
  logic                       closed_sensor_level;

  modport source (output valid, output op, output open_sensor_level,
                  output closed_sensor_level, input ready);
  modport sink   (input valid, input op, input open_sensor_level,
                  input closed_sensor_level, output ready);
endinterface

interface lsdmc_out_if;
  logic                           valid;
  logic                           ready;
  logic                           move_finished;
  logic                           move_success;
  logic [lsdmc_pkg::DIR_W-1:0]    ended_direction;
  logic [lsdmc_pkg::REASON_W-1:0] end_reason;
  logic [lsdmc_pkg::DIR_W-1:0]    motor_drive;
  logic [lsdmc_pkg::POS_W-1:0]    door_position;

  modport source (output valid, output move_finished, output move_success,
                  output ended_direction, output end_reason, output motor_drive,
                  output door_position, input ready);
  modport sink   (input valid, input move_finished, input move_success,
                  input ended_direction, input end_reason, input motor_drive,
                  input door_position, output ready);
endinterface

[rtl/core/limit_switch_door_motor_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limit switch door motor controller
// Qualifies two active-low hall sensors, drives the motor toward the target
// limit and reports how each move ends.
// ----------------------------------------------------------------------------
// Every command beat yields exactly one result beat in the cycle after it
// is accepted. A new beat is taken in every cycle, while the result register
// is empty or its beat is being taken in the same cycle, so the sustained
// rate is one beat per cycle. Sensor qualification, move timer and the end
// decision settle between the state registers and the result register.
// ----------------------------------------------------------------------------
module limit_switch_door_motor_controller (
  input  logic                                  clk,
  input  logic                                  rst_n,
  lsdmc_in_if.sink                              in_ch,
  lsdmc_out_if.source                           out_ch,
  input  logic                                  cfg_we,
  input  logic [lsdmc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lsdmc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import lsdmc_pkg::*;

  logic [STABLE_W-1:0] stable_r;
  logic [TMO_W-1:0]    timeout_r;

  dir_t              dir_r, dir_nxt;
  logic [ELAP_W-1:0] elapsed_r, elapsed_nxt;
  logic [CNT_W-1:0]  open_cnt_r, open_cnt_nxt, closed_cnt_r, closed_cnt_nxt;
  logic              open_seen_r, open_seen_nxt, closed_seen_r, closed_seen_nxt;

  logic    out_valid_r;
  logic    finished_r, finished_nxt;
  logic    success_r, success_nxt;
  dir_t    ended_r, ended_nxt;
  reason_t reason_r, reason_nxt;
  pos_t    pos_r, pos_nxt;

  logic accept;
  logic open_act, closed_act;
  op_t  op;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign op          = op_t'(in_ch.op);

  always_comb begin
    dir_nxt         = dir_r;
    elapsed_nxt     = elapsed_r;
    open_cnt_nxt    = open_cnt_r;
    open_seen_nxt   = open_seen_r;
    closed_cnt_nxt  = closed_cnt_r;
    closed_seen_nxt = closed_seen_r;
    finished_nxt    = 1'b0;
    success_nxt     = 1'b0;
    ended_nxt       = DIR_NONE;
    reason_nxt      = RSN_NONE;

    case (op)
      OP_OPEN: begin
        dir_nxt     = DIR_OPEN;
        elapsed_nxt = '0;
      end
      OP_CLOSE: begin
        dir_nxt     = DIR_CLOSE;
        elapsed_nxt = '0;
      end
      OP_TICK: begin
        if (!in_ch.open_sensor_level) begin
          open_seen_nxt = 1'b1;
          if (!open_seen_r) begin
            open_cnt_nxt = '0;
          end else if (open_cnt_r != CNT_MAX) begin
            open_cnt_nxt = open_cnt_r + 1'b1;
          end
        end else begin
          open_seen_nxt = 1'b0;
          open_cnt_nxt  = '0;
        end
        if (!in_ch.closed_sensor_level) begin
          closed_seen_nxt = 1'b1;
          if (!closed_seen_r) begin
            closed_cnt_nxt = '0;
          end else if (closed_cnt_r != CNT_MAX) begin
            closed_cnt_nxt = closed_cnt_r + 1'b1;
          end
        end else begin
          closed_seen_nxt = 1'b0;
          closed_cnt_nxt  = '0;
        end
      end
      default: begin
      end
    endcase

    open_act   = open_seen_nxt && (open_cnt_nxt >= {1'b0, stable_r});
    closed_act = closed_seen_nxt && (closed_cnt_nxt >= {1'b0, stable_r});
    case ({open_act, closed_act})
      2'b11:   pos_nxt = POS_CONFLICT;
      2'b10:   pos_nxt = POS_OPEN;
      2'b01:   pos_nxt = POS_CLOSED;
      default: pos_nxt = POS_BETWEEN;
    endcase

    if (op == OP_TICK && dir_r != DIR_NONE) begin
      if (elapsed_r != ELAP_MAX) begin
        elapsed_nxt = elapsed_r + 1'b1;
      end
      if (pos_nxt == POS_CONFLICT) begin
        finished_nxt = 1'b1;
        reason_nxt   = RSN_CONFLICT;
      end else if (dir_r == DIR_OPEN && pos_nxt == POS_OPEN) begin
        finished_nxt = 1'b1;
        success_nxt  = 1'b1;
        reason_nxt   = RSN_OPENED;
      end else if (dir_r == DIR_CLOSE && pos_nxt == POS_CLOSED) begin
        finished_nxt = 1'b1;
        success_nxt  = 1'b1;
        reason_nxt   = RSN_CLOSED;
      end else if (elapsed_nxt >= timeout_r) begin
        finished_nxt = 1'b1;
        reason_nxt   = RSN_TIMEOUT;
      end
      if (finished_nxt) begin
        ended_nxt = dir_r;
        dir_nxt   = DIR_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r  <= STABLE_RESET;
      timeout_r <= TMO_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_SENSOR_STABLE) begin
        stable_r <= cfg_wdata[STABLE_W-1:0];
      end else if (cfg_index == REG_MOTOR_TIMEOUT) begin
        timeout_r <= cfg_wdata[TMO_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r         <= DIR_NONE;
      elapsed_r     <= '0;
      open_cnt_r    <= '0;
      open_seen_r   <= 1'b0;
      closed_cnt_r  <= '0;
      closed_seen_r <= 1'b0;
    end else if (accept) begin
      dir_r         <= dir_nxt;
      elapsed_r     <= elapsed_nxt;
      open_cnt_r    <= open_cnt_nxt;
      open_seen_r   <= open_seen_nxt;
      closed_cnt_r  <= closed_cnt_nxt;
      closed_seen_r <= closed_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      finished_r <= finished_nxt;
      success_r  <= success_nxt;
      ended_r    <= ended_nxt;
      reason_r   <= reason_nxt;
      pos_r      <= pos_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.move_finished   = finished_r;
  assign out_ch.move_success    = success_r;
  assign out_ch.ended_direction = ended_r;
  assign out_ch.end_reason      = reason_r;
  assign out_ch.motor_drive     = dir_r;
  assign out_ch.door_position   = pos_r;

  a_end_stops_motor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && finished_r |-> dir_r == DIR_NONE)
    else $error("motor still driven after a move ended");

  a_success_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && success_r |->
      finished_r && (reason_r == RSN_OPENED || reason_r == RSN_CLOSED))
    else $error("success reported without a reached limit");

  a_no_end_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !finished_r |-> ended_r == DIR_NONE && reason_r == RSN_NONE)
    else $error("end fields set on a beat that ended no move");

  a_start_drives: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (op == OP_OPEN || op == OP_CLOSE) |=>
      dir_r == dir_t'($past(in_ch.op)) && elapsed_r == '0)
    else $error("start command did not set direction and clear timer");

endmodule

[verif/limit_switch_door_motor_controller_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Door motor controller testbench
// Drives command and tick beats with random gaps on both channels, keeps a
// cycle-true copy of the controller state and checks every result beat in
// order. A short scripted part covers the corner cases. Random move sequences
// follow under several register settings.
// ----------------------------------------------------------------------------
module limit_switch_door_motor_controller_tb;
  import lsdmc_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 10;
  localparam int MAX_CYCLES   = 3_000_000;
  localparam int NUM_PHASES   = 7;
  localparam int PHASE_BEATS  = 250;
  localparam int SCRIPT_ROWS  = 25;

  localparam logic [OP_W-1:0]      OP_UNUSED    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic    finished;
    logic    success;
    dir_t    ended;
    reason_t reason;
    dir_t    drive;
    pos_t    pos;
  } door_result_t;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [OP_W-1:0]       op;
    logic                  open_lvl;
    logic                  closed_lvl;
    logic                  typed;
    door_result_t          want;
    logic [STABLE_W-1:0]   stable;
    logic [TMO_W-1:0]      timeout;
  } script_row_t;

  localparam door_result_t IDLE_RES =
    '{1'b0, 1'b0, DIR_NONE, RSN_NONE, DIR_NONE, POS_BETWEEN};

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lsdmc_in_if  in_bus ();
  lsdmc_out_if out_bus ();

  limit_switch_door_motor_controller uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the controller state and its registers.
  logic [STABLE_W-1:0] sens_stable;
  logic [TMO_W-1:0]    move_limit;
  dir_t                move_dir;
  logic [ELAP_W-1:0]   move_elapsed;
  logic [CNT_W-1:0]    open_cnt;
  logic [CNT_W-1:0]    closed_cnt;
  logic                open_seen;
  logic                closed_seen;

  door_result_t door_results_due[$];
  bit gaps_on = 1'b1;
  bit long_hold_done = 1'b0;
  int errors = 0;
  int cmd_beats = 0;
  int results_seen = 0;
  int cycles = 0;
  int ended_by [8] = '{default: 0};

  script_row_t script [SCRIPT_ROWS] = '{
    '{ROW_BEAT, OP_TICK,   1'b1, 1'b1, 1'b1, IDLE_RES, '0, '0},
    '{ROW_BEAT, OP_UNUSED, 1'b0, 1'b0, 1'b1, IDLE_RES, '0, '0},
    '{ROW_BEAT, OP_OPEN,   1'b1, 1'b1, 1'b1,
      '{1'b0, 1'b0, DIR_NONE, RSN_NONE, DIR_OPEN, POS_BETWEEN}, '0, '0},
    '{ROW_BEAT, OP_TICK,   1'b0, 1'b1, 1'b0, IDLE_RES, '0, '0},
    '{ROW_BEAT, OP_CLOSE,  1'b1, 1'b1, 1'b0, IDLE_RES, '0, '0},
    '{ROW_CFG,  OP_TICK,   1'b1, 1'b1, 1'b0, IDLE_RES, 16'd0, 20'd1},
    '{ROW_BEAT, OP_TICK,   1'b1, 1'b1, 1'b1,
      '{1'b1, 1'b0, DIR_CLOSE, RSN_TIMEOUT, DIR_NONE, POS_BETWEEN}, '0, '0},
    '{ROW_BEAT, OP_OPEN,   1'b1, 1'b1, 1'b0, IDLE_RES, '0, '0},
    '{ROW_BEAT, OP_TICK,   1'b0, 1'b1, 1'b1,
      '{1'b1, 1'b1, DIR_OPEN, RSN_OPENED, DIR_NONE, POS_OPEN}, '0, '0},
    '{ROW_BEAT, OP_CLOSE,  1'b0, 1'b0, 1'b0, IDLE_RES, '0, '0},
    '{ROW_BEAT, OP_TICK,   1'b0, 1'b0, 1'b1,
      '{1'b1, 1'b0, DIR_CLOSE, RSN_CONFLICT, DIR_NONE, POS_CONFLICT}, '0, '0},
    '{ROW_BEAT, OP_TICK,   1'b1, 1'b0, 1'b0, IDLE_RES, '0, '0},
    '{ROW_BEAT, OP_CLOSE,  1'b1, 1'b1, 1'b0, IDLE_RES, '0, '0},
    '{ROW_BEAT, OP_TICK,   1'b1, 1'b0, 1'b1,
      '{1'b1, 1'b1, DIR_CLOSE, RSN_CLOSED, DIR_NONE, POS_CLOSED}, '0, '0},
    '{ROW_CFG,  OP_TICK,   1'b1, 1'b1, 1'b0, IDLE_RES, 16'd3, 20'd0},
    '{ROW_BEAT, OP_OPEN,   1'b1, 1'b1, 1'b0, IDLE_RES, '0, '0},
    '{ROW_BEAT, OP_TICK,   1'b1, 1'b1, 1'b1,
      '{1'b1, 1'b0, DIR_OPEN, RSN_TIMEOUT, DIR_NONE, POS_BETWEEN}, '0, '0},
    '{ROW_CFG,  OP_TICK,   1'b1, 1'b1, 1'b0, IDLE_RES, 16'd2, '1},
    '{ROW_BEAT, OP_OPEN,   1'b0, 1'b0, 1'b0, IDLE_RES, '0, '0},
    '{ROW_BEAT, OP_TICK,   1'b0, 1'b1, 1'b0, IDLE_RES, '0, '0},
    '{ROW_BEAT, OP_TICK,   1'b0, 1'b1, 1'b0, IDLE_RES, '0, '0},
    '{ROW_BEAT, OP_TICK,   1'b0, 1'b1, 1'b0, IDLE_RES, '0, '0},
    '{ROW_BEAT, OP_UNUSED, 1'b1, 1'b1, 1'b0, IDLE_RES, '0, '0},
    '{ROW_BEAT, OP_CLOSE,  1'b1, 1'b1, 1'b0, IDLE_RES, '0, '0},
    '{ROW_BEAT, OP_TICK,   1'b1, 1'b1, 1'b0, IDLE_RES, '0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= MAX_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void sample_level(input logic lvl, inout logic [CNT_W-1:0] cnt,
                                       inout logic seen);
    if (!lvl) begin
      if (!seen) begin
        seen = 1'b1;
        cnt  = '0;
      end else if (cnt != CNT_MAX) begin
        cnt = cnt + 1'b1;
      end
    end else begin
      seen = 1'b0;
      cnt  = '0;
    end
  endfunction

  function automatic pos_t door_position_now();
    logic open_act, closed_act;
    open_act   = open_seen && (open_cnt >= CNT_W'(sens_stable));
    closed_act = closed_seen && (closed_cnt >= CNT_W'(sens_stable));
    if (open_act && closed_act) return POS_CONFLICT;
    if (open_act) return POS_OPEN;
    if (closed_act) return POS_CLOSED;
    return POS_BETWEEN;
  endfunction

  function automatic door_result_t advance_door(input logic [OP_W-1:0] op,
                                                input logic open_lvl, closed_lvl);
    door_result_t r;
    pos_t p;
    r = IDLE_RES;
    if (op == OP_OPEN || op == OP_CLOSE) begin
      move_dir     = dir_t'(op);
      move_elapsed = '0;
    end else if (op == OP_TICK) begin
      sample_level(open_lvl, open_cnt, open_seen);
      sample_level(closed_lvl, closed_cnt, closed_seen);
      p = door_position_now();
      if (move_dir != DIR_NONE) begin
        if (move_elapsed != ELAP_MAX) move_elapsed = move_elapsed + 1'b1;
        if (p == POS_CONFLICT) begin
          r.reason = RSN_CONFLICT;
        end else if (move_dir == DIR_OPEN && p == POS_OPEN) begin
          r.success = 1'b1;
          r.reason  = RSN_OPENED;
        end else if (move_dir == DIR_CLOSE && p == POS_CLOSED) begin
          r.success = 1'b1;
          r.reason  = RSN_CLOSED;
        end else if (move_elapsed >= move_limit) begin
          r.reason = RSN_TIMEOUT;
        end
        if (r.reason != RSN_NONE) begin
          r.finished = 1'b1;
          r.ended    = move_dir;
          move_dir   = DIR_NONE;
        end
      end
    end
    r.drive = move_dir;
    r.pos   = door_position_now();
    return r;
  endfunction

  // Valid stays high after an accepted beat; the caller either sends the next
  // beat in the same time step or calls drain_results, which lowers it.
  task automatic send_beat(input logic [OP_W-1:0] op, input logic open_lvl,
                           input logic closed_lvl, input logic typed = 1'b0,
                           input door_result_t want = IDLE_RES);
    int gap;
    door_result_t predicted;
    gap = gaps_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid               <= 1'b1;
    in_bus.op                  <= op;
    in_bus.open_sensor_level   <= open_lvl;
    in_bus.closed_sensor_level <= closed_lvl;
    do @(posedge clk); while (!in_bus.ready);
    predicted = advance_door(op, open_lvl, closed_lvl);
    door_results_due.push_back(typed ? want : predicted);
    if (op != OP_UNUSED) cmd_beats++;
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (door_results_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_regs(input logic [STABLE_W-1:0] stable,
                              input logic [TMO_W-1:0] timeout);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SENSOR_STABLE;
    cfg_wdata <= {(CFG_DATA_W-STABLE_W)'($urandom), stable};
    @(posedge clk);
    sens_stable = stable;
    cfg_index <= REG_MOTOR_TIMEOUT;
    cfg_wdata <= CFG_DATA_W'(timeout);
    @(posedge clk);
    move_limit = timeout;
    cfg_index <= $urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI;
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One move: a start toward a target, then ticks shaped to reach it, run into
  // a conflict, time out, restart halfway, or jitter at random.
  task automatic run_move_sequence();
    dir_t target;
    int mode, n, d, span, k;
    logic [OP_W-1:0] op;
    logic tgt_lvl, oth_lvl;
    target = $urandom_range(0, 1) ? DIR_OPEN : DIR_CLOSE;
    mode = $urandom_range(0, 9);
    span = (int'(sens_stable) < 52) ? int'(sens_stable) + 8 : 60;
    if (mode == 6) n = (int'(move_limit) < 78) ? int'(move_limit) + 2 : 80;
    else n = $urandom_range(1, span);
    d = (mode == 5) ? $urandom_range(0, n) : $urandom_range(0, n / 3);
    gaps_on = ($urandom_range(0, 3) != 0);
    send_beat(target == DIR_OPEN ? OP_OPEN : OP_CLOSE, 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
    for (k = 0; k < n; k++) begin
      op = OP_TICK;
      tgt_lvl = 1'b1;
      oth_lvl = ($urandom_range(0, 9) != 0);
      case (mode)
        5: begin
          tgt_lvl = (k < d);
          oth_lvl = (k < d);
        end
        6: tgt_lvl = 1'b1;
        7: begin
          tgt_lvl = 1'($urandom_range(0, 1));
          oth_lvl = 1'($urandom_range(0, 1));
          if ($urandom_range(0, 7) == 0) begin
            op = ($urandom_range(0, 2) == 0) ? OP_UNUSED :
                 ($urandom_range(0, 1) ? OP_OPEN : OP_CLOSE);
          end
        end
        default: begin
          tgt_lvl = (k >= d) ? ($urandom_range(0, 11) == 0) : 1'b1;
          if (mode == 8 && k == d / 2) op = $urandom_range(0, 1) ? OP_OPEN : OP_CLOSE;
        end
      endcase
      if (target == DIR_OPEN) send_beat(op, tgt_lvl, oth_lvl);
      else send_beat(op, oth_lvl, tgt_lvl);
    end
  endtask

  initial begin : result_checker
    door_result_t want;
    int gap;
    out_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = gaps_on ? $urandom_range(0, 13) : 0;
      if (!long_hold_done && results_seen >= 400) begin
        gap = 90;
        long_hold_done = 1'b1;
      end
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      results_seen++;
      if (door_results_due.size() == 0) begin
        $error("result beat with no command waiting for it");
        errors++;
      end else begin
        want = door_results_due.pop_front();
        if (out_bus.move_finished !== want.finished) begin
          $error("move_finished: expected %0d, got %0d", want.finished,
                 out_bus.move_finished);
          errors++;
        end
        if (out_bus.move_success !== want.success) begin
          $error("move_success: expected %0d, got %0d", want.success,
                 out_bus.move_success);
          errors++;
        end
        if (out_bus.ended_direction !== want.ended) begin
          $error("ended_direction: expected %0d, got %0d", want.ended,
                 out_bus.ended_direction);
          errors++;
        end
        if (out_bus.end_reason !== want.reason) begin
          $error("end_reason: expected %0d, got %0d", want.reason, out_bus.end_reason);
          errors++;
        end
        if (out_bus.motor_drive !== want.drive) begin
          $error("motor_drive: expected %0d, got %0d", want.drive, out_bus.motor_drive);
          errors++;
        end
        if (out_bus.door_position !== want.pos) begin
          $error("door_position: expected %0d, got %0d", want.pos,
                 out_bus.door_position);
          errors++;
        end
        if (want.finished) ended_by[want.reason]++;
      end
    end
  end

  initial begin : stimulus
    int i, ph, phase_start;
    logic [STABLE_W-1:0] st;
    logic [TMO_W-1:0] tm;
    rst_n                      <= 1'b0;
    cfg_we                     <= 1'b0;
    cfg_index                  <= REG_SENSOR_STABLE;
    cfg_wdata                  <= '0;
    in_bus.valid               <= 1'b0;
    in_bus.op                  <= OP_TICK;
    in_bus.open_sensor_level   <= 1'b1;
    in_bus.closed_sensor_level <= 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    sens_stable  = STABLE_RESET;
    move_limit   = TMO_RESET;
    move_dir     = DIR_NONE;
    move_elapsed = '0;
    open_cnt     = '0;
    closed_cnt   = '0;
    open_seen    = 1'b0;
    closed_seen  = 1'b0;

    for (i = 0; i < SCRIPT_ROWS; i++) begin
      if (script[i].kind == ROW_CFG) begin
        drain_results();
        program_regs(script[i].stable, script[i].timeout);
      end else begin
        send_beat(script[i].op, script[i].open_lvl, script[i].closed_lvl,
                  script[i].typed, script[i].want);
      end
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin st = '0; tm = 20'd1; end
        1: begin st = 16'd1; tm = 20'd5; end
        2: begin st = 16'd4; tm = 20'd20; end
        3: begin
          st = STABLE_W'($urandom_range(0, 10));
          tm = TMO_W'($urandom_range(1, 40));
        end
        4: begin st = STABLE_RESET; tm = 20'd70; end
        5: begin st = STABLE_W'($urandom_range(0, 6)); tm = '1; end
        default: begin st = '1; tm = TMO_W'($urandom_range(1, 30)); end
      endcase
      drain_results();
      program_regs(st, tm);
      phase_start = cmd_beats;
      while (cmd_beats - phase_start < PHASE_BEATS) run_move_sequence();
    end

    drain_results();

    $display("Run covered %0d command beats and %0d result beats in %0d cycles.",
             cmd_beats, results_seen, cycles);
    $display("Moves ended: %0d opened, %0d closed, %0d on conflict, %0d on timeout.",
             ended_by[RSN_OPENED], ended_by[RSN_CLOSED], ended_by[RSN_CONFLICT],
             ended_by[RSN_TIMEOUT]);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/lsdmc_pkg.sv
rtl/core/lsdmc_if.sv
rtl/core/limit_switch_door_motor_controller.sv
verif/limit_switch_door_motor_controller_tb.sv
